@@ src/dtq_pkg.sv @@
// shared types, constants and codes of the deadline timer queue
package dtq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
    localparam int SLOT_FW     = 4;
    localparam int TAG_W       = 16;
    localparam int TIME_W      = 64;

    localparam logic [1:0] ACT_REGISTER = 2'd0;
    localparam logic [1:0] ACT_CANCEL   = 2'd1;
    localparam logic [1:0] ACT_CHECK    = 2'd2;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;

    localparam logic [1:0] KIND_REGISTERED = 2'd0;
    localparam logic [1:0] KIND_FIRED      = 2'd1;
    localparam logic [1:0] KIND_DONE       = 2'd2;
    localparam logic [1:0] KIND_FULL       = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [TIME_W-1:0]  now_time;
        logic [TIME_W-1:0]  interval;
        logic [TAG_W-1:0]   callback_tag;
        logic [SLOT_FW-1:0] slot;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [SLOT_FW-1:0] slot_out;
        logic [TAG_W-1:0]   tag_out;
        logic               pending;
        logic               last;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIRE
    } t_state;

    typedef struct packed {
        logic do_reg;
        logic do_cancel;
        logic scan_start;
        logic scan_step;
        logic fire;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic best_vld;
    } t_sts;

endpackage

@@ src/dtq_ram.sv @@
// generic simple dual-port ram with registered read
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

@@ src/dtq_ctrl.sv @@
// controller state machine of the timer queue
module dtq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_action,
    input  dtq_pkg::t_sts i_sts,
    output dtq_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import dtq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == ACT_REGISTER) begin
                        o_cmd.do_reg = 1'b1;
                    end else if (i_action == ACT_CANCEL) begin
                        o_cmd.do_cancel = 1'b1;
                    end else if (i_action == ACT_CHECK) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_FIRE;
                end
            end
            S_FIRE: begin
                if (i_sts.best_vld) begin
                    o_cmd.fire       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

@@ src/dtq_datapath.sv @@
// armed bits, timer ram, minimum search and result register
module dtq_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dtq_pkg::t_in  i_item,
    input  dtq_pkg::t_cmd i_cmd,
    output dtq_pkg::t_sts o_sts,
    output dtq_pkg::t_out o_result,
    output logic          o_strobe
);
    import dtq_pkg::*;

    localparam int RAM_W = TIME_W + TAG_W;

    logic [TIMER_SLOTS-1:0] r_armed;
    logic [TIME_W-1:0]      r_now;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_rd_vld;
    logic [SLOT_W-1:0]      r_rd_idx;
    logic                   r_best_vld;
    logic [SLOT_W-1:0]      r_best_idx;
    logic [TIME_W-1:0]      r_best_dl;
    logic [TAG_W-1:0]       r_best_tag;
    t_out                   r_out;
    logic                   r_strobe;

    logic [SLOT_W-1:0] free_idx;
    logic              free_vld;
    logic [RAM_W-1:0]  rd_data;
    logic [TIME_W-1:0] rd_dl;
    logic [TAG_W-1:0]  rd_tag;
    logic              take;
    logic              issue;
    logic [SLOT_W-1:0] cancel_idx;
    logic              cancel_ok;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        free_vld = 1'b0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!r_armed[i]) begin
                free_idx = SLOT_W'(i);
                free_vld = 1'b1;
            end
        end
    end

    assign issue      = i_cmd.scan_step && (r_cnt < CNT_W'(TIMER_SLOTS));
    assign rd_dl      = rd_data[RAM_W-1 -: TIME_W];
    assign rd_tag     = rd_data[TAG_W-1:0];
    assign take       = r_rd_vld && r_armed[r_rd_idx] && (rd_dl < r_now)
                        && (!r_best_vld || (rd_dl < r_best_dl));
    assign cancel_idx = SLOT_W'(i_item.slot);
    assign cancel_ok  = (int'(i_item.slot) < TIMER_SLOTS);

    dtq_ram #(
        .WIDTH(RAM_W),
        .DEPTH(TIMER_SLOTS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.do_reg && free_vld),
        .i_wr_addr(free_idx),
        .i_wr_data({i_item.now_time + i_item.interval, i_item.callback_tag}),
        .i_rd_addr(r_cnt[SLOT_W-1:0]),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= '0;
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cmd.do_reg && free_vld) begin
                r_armed[free_idx] <= 1'b1;
            end
            if (i_cmd.do_cancel && cancel_ok) begin
                r_armed[cancel_idx] <= 1'b0;
            end
            if (i_cmd.fire) begin
                r_armed[r_best_idx] <= 1'b0;
            end
            if (i_cmd.do_reg || i_cmd.fire || i_cmd.done) begin
                r_strobe <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_cnt      <= '0;
                r_rd_vld   <= 1'b0;
                r_best_vld <= 1'b0;
            end else begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (take) begin
                    r_best_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start && !i_cmd.fire) begin
            r_now <= i_item.now_time;
        end
        r_rd_idx <= r_cnt[SLOT_W-1:0];
        if (take) begin
            r_best_idx <= r_rd_idx;
            r_best_dl  <= rd_dl;
            r_best_tag <= rd_tag;
        end
        if (i_cmd.do_reg) begin
            r_out.kind     <= free_vld ? KIND_REGISTERED : KIND_FULL;
            r_out.slot_out <= free_vld ? SLOT_FW'(free_idx) : '0;
            r_out.tag_out  <= '0;
            r_out.pending  <= 1'b0;
            r_out.last     <= 1'b1;
        end else if (i_cmd.fire) begin
            r_out.kind     <= KIND_FIRED;
            r_out.slot_out <= SLOT_FW'(r_best_idx);
            r_out.tag_out  <= r_best_tag;
            r_out.pending  <= 1'b0;
            r_out.last     <= 1'b0;
        end else if (i_cmd.done) begin
            r_out.kind     <= KIND_DONE;
            r_out.slot_out <= '0;
            r_out.tag_out  <= '0;
            r_out.pending  <= |r_armed;
            r_out.last     <= 1'b1;
        end
    end

    assign o_sts.scan_end = (r_cnt == CNT_W'(TIMER_SLOTS)) && !r_rd_vld;
    assign o_sts.best_vld = r_best_vld;
    assign o_result       = r_out;
    assign o_strobe       = r_strobe;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(TIMER_SLOTS))
        else $error("scan counter past slot count");
    a_fire_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fire |-> (r_best_vld && r_armed[r_best_idx]))
        else $error("fire without an armed best slot");
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_out.last) |-> (r_out.kind == KIND_FIRED))
        else $error("non-final result that is not a fired timer");
endmodule

@@ src/deadline_timer_queue.sv @@
// top level of the deadline timer queue: controller plus datapath
//
// channel   direction  handshake               payload
// item      in         i_start && !o_busy      i_item   (t_in)
// result    out        o_strobe, one cycle     o_result (t_out)
//
// register: result strobes the cycle after the item is taken; cancel: no result
// check: a full scan of TIMER_SLOTS ram reads plus a decision in S_FIRE per fired
//   timer, then one more scan for the done result
// one ram read port sets the scan length; register and cancel do not raise busy
// reset is synchronous active low and disarms every slot at once
// the receiver cannot stall: each result is valid for exactly one cycle
module deadline_timer_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  dtq_pkg::t_in  i_item,
    output logic          o_busy,
    output logic          o_strobe,
    output dtq_pkg::t_out o_result
);
    import dtq_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic busy;

    // controller decides the command per cycle and holds the state machine, datapath holds the rest of the state
    dtq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_action(i_item.action),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // armed bits, timer ram, earliest-deadline search, result register
    dtq_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_result(o_result),
        .o_strobe(o_strobe)
    );

    assign o_busy = busy;
endmodule
